[rtl/rbst_pkg.sv]
package rbst_pkg;

  localparam int QW       = 32;          // Q16.16 word
  localparam int FRAC     = 16;          // fraction bits
  localparam int NW       = QW + FRAC;   // dividend magnitude width
  localparam int EPS_W    = 17;
  localparam int NAXIS    = 3;
  localparam int NLANE    = 2 * NAXIS;   // two slab distances per axis
  localparam int QDEPTH   = 2;           // default front/back queue depth

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);
  localparam logic signed [QW-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;

  typedef logic signed [QW-1:0] q_t;

  // One axis as classified by the front end
  typedef struct packed {
    logic                 par;     // direction too small: parallel
    logic                 pmiss;   // parallel and origin outside slab
    logic [1:0]           neg;     // quotient sign, per corner
    logic [1:0]           ovf;     // quotient magnitude >= 2^32
    logic [QW-1:0]        dmag;    // |dir|
    logic [1:0][QW-1:0]   nmag;    // |corner - origin|
  } axis_t;

  // Queue entry between front and back
  typedef struct packed {
    axis_t [NAXIS-1:0]          ax;
    logic  [NAXIS-1:0][QW-1:0]  org;
    logic  [NAXIS-1:0][QW-1:0]  dir;
  } fent_t;

  // Side data carried along the divider
  typedef struct packed {
    logic [NAXIS-1:0]           par;
    logic [NAXIS-1:0]           pmiss;
    logic [NLANE-1:0]           neg;
    logic [NLANE-1:0]           ovf;
    logic [NAXIS-1:0][QW-1:0]   org;
    logic [NAXIS-1:0][QW-1:0]   dir;
  } side_t;

endpackage

[rtl/rbst_front.sv]
module rbst_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rbst_pkg::EPS_W-1:0]    eps,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0][rbst_pkg::QW-1:0]  org,
  input  logic [2:0][rbst_pkg::QW-1:0]  dir,
  input  logic [2:0][rbst_pkg::QW-1:0]  bmin,
  input  logic [2:0][rbst_pkg::QW-1:0]  bmax,
  output logic                          f_valid,
  input  logic                          f_full,
  output rbst_pkg::fent_t               f_data
);
  import rbst_pkg::*;

  logic  f_valid_r;
  fent_t f_data_r;
  fent_t f_data_nxt;
  logic  push;

  logic signed [QW:0]   d1 [NAXIS];
  logic signed [QW:0]   d2 [NAXIS];

  assign push     = f_valid_r && !f_full;
  assign in_ready = !f_valid_r || !f_full;
  assign f_valid  = f_valid_r;
  assign f_data   = f_data_r;

  // Classify each axis and prepare divider operands
  always_comb begin
    f_data_nxt = '0;
    for (int a = 0; a < NAXIS; a++) begin
      d1[a] = $signed({bmin[a][QW-1], bmin[a]}) - $signed({org[a][QW-1], org[a]});
      d2[a] = $signed({bmax[a][QW-1], bmax[a]}) - $signed({org[a][QW-1], org[a]});
      f_data_nxt.org[a] = org[a];
      f_data_nxt.dir[a] = dir[a];
      f_data_nxt.ax[a].dmag = dir[a][QW-1] ? (~dir[a] + QW'(1)) : dir[a];
      f_data_nxt.ax[a].par  = (dir[a] == '0) ||
                              (f_data_nxt.ax[a].dmag < {{(QW-EPS_W){1'b0}}, eps});
      f_data_nxt.ax[a].pmiss = f_data_nxt.ax[a].par &&
                               (($signed(org[a]) < $signed(bmin[a])) ||
                                ($signed(org[a]) > $signed(bmax[a])));
      f_data_nxt.ax[a].nmag[0] = d1[a][QW] ? QW'(-d1[a]) : QW'(d1[a]);
      f_data_nxt.ax[a].nmag[1] = d2[a][QW] ? QW'(-d2[a]) : QW'(d2[a]);
      f_data_nxt.ax[a].neg[0]  = d1[a][QW] ^ dir[a][QW-1];
      f_data_nxt.ax[a].neg[1]  = d2[a][QW] ^ dir[a][QW-1];
      for (int k = 0; k < 2; k++) begin
        f_data_nxt.ax[a].ovf[k] =
          {{FRAC{1'b0}}, f_data_nxt.ax[a].nmag[k], {FRAC{1'b0}}} >=
          {f_data_nxt.ax[a].dmag, {QW{1'b0}}};
      end
    end
  end

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_data_r <= f_data_nxt;
    end
  end

endmodule

[rtl/rbst_queue.sv]
module rbst_queue #(
  parameter int DEPTH = rbst_pkg::QDEPTH,
  parameter int W     = $bits(rbst_pkg::fent_t)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         full,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  // Advance pointers, wrapping at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      if (do_pop)  rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> count_r == $past(count_r) - CW'(1))
    else $error("queue count did not drop on pop");
`endif

endmodule

[rtl/rbst_div.sv]
module rbst_div #(
  parameter int NL = rbst_pkg::NLANE,
  parameter int QW = rbst_pkg::QW,
  parameter int NW = rbst_pkg::NW,
  parameter int SW = $bits(rbst_pkg::side_t)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [NL-1:0][NW-1:0]  in_num,
  input  logic [NL-1:0][QW-1:0]  in_den,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic [NL-1:0][QW-1:0]  out_quo,
  output logic [SW-1:0]          out_side
);
  // One quotient bit per stage, most significant first
  logic [NL-1:0][NW-1:0] rem_r  [QW];
  logic [NL-1:0][QW-1:0] den_r  [QW];
  logic [NL-1:0][QW-1:0] quo_r  [QW];
  logic [SW-1:0]         side_r [QW];
  logic [QW-1:0]         vld_r;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NL-1:0][NW-1:0]   rin, rnx;
    logic [NL-1:0][QW-1:0]   din, qin, qnx;
    logic [NL-1:0][2*QW-1:0] dsh, rwide;
    logic [NL-1:0]           ge;
    logic [SW-1:0]           sin;
    logic                    vin;

    if (s == 0) begin : g_first
      assign rin = in_num;
      assign din = in_den;
      assign qin = '0;
      assign sin = in_side;
      assign vin = in_valid;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign din = den_r[s-1];
      assign qin = quo_r[s-1];
      assign sin = side_r[s-1];
      assign vin = vld_r[s-1];
    end

    // Trial subtract of the shifted divisor
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        dsh[l]   = {{QW{1'b0}}, din[l]} << (QW - 1 - s);
        rwide[l] = (2*QW)'(rin[l]);
        ge[l]    = rwide[l] >= dsh[l];
        rnx[l]   = ge[l] ? NW'(rwide[l] - dsh[l]) : rin[l];
        qnx[l]   = qin[l] | (ge[l] ? (QW'(1) << (QW - 1 - s)) : QW'(0));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rnx;
        den_r[s]  <= din;
        quo_r[s]  <= qnx;
        side_r[s] <= sin;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

[rtl/rbst_back.sv]
module rbst_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_pop,
  input  rbst_pkg::fent_t               in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [rbst_pkg::QW-1:0]       out_entry,
  output logic [2:0][rbst_pkg::QW-1:0]  out_point
);
  import rbst_pkg::*;

  function automatic q_t sat_quo(input logic [QW-1:0] mag, input logic neg,
                                 input logic ovf);
    q_t r;
    if (!neg) r = (ovf || mag[QW-1]) ? Q_MAX : q_t'(mag);
    else      r = (ovf || (mag[QW-1] && (mag[QW-2:0] != '0))) ? Q_MIN
                                                              : q_t'(~mag + QW'(1));
    return r;
  endfunction

  logic adv;

  logic [NLANE-1:0][NW-1:0] dnum;
  logic [NLANE-1:0][QW-1:0] dden;
  side_t                    dside_in, dside;
  logic                     dvalid;
  logic [NLANE-1:0][QW-1:0] dquo;

  assign adv    = !out_valid || out_ready;
  assign in_pop = adv && in_valid;

  // Spread the queue entry over the divider lanes
  always_comb begin
    dside_in = '0;
    for (int a = 0; a < NAXIS; a++) begin
      dside_in.par[a]   = in_data.ax[a].par;
      dside_in.pmiss[a] = in_data.ax[a].pmiss;
      dside_in.org[a]   = in_data.org[a];
      dside_in.dir[a]   = in_data.dir[a];
      for (int k = 0; k < 2; k++) begin
        dnum[2*a+k]         = {in_data.ax[a].nmag[k], {FRAC{1'b0}}};
        dden[2*a+k]         = in_data.ax[a].dmag;
        dside_in.neg[2*a+k] = in_data.ax[a].neg[k];
        dside_in.ovf[2*a+k] = in_data.ax[a].ovf[k];
      end
    end
  end

  rbst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .in_num    (dnum),
    .in_den    (dden),
    .in_side   (dside_in),
    .out_valid (dvalid),
    .out_quo   (dquo),
    .out_side  (dside)
  );

  // Stage A: saturate and order the slab distances; a parallel axis takes the full range
  q_t   t_lo [NAXIS], t_hi [NAXIS];
  q_t   t0, t1;
  logic a_valid_r;
  q_t   a_lo_r [NAXIS], a_hi_r [NAXIS];
  logic a_pmiss_r;
  logic [NAXIS-1:0][QW-1:0] a_org_r, a_dir_r;

  always_comb begin
    t0 = '0;
    t1 = '0;
    for (int a = 0; a < NAXIS; a++) begin
      t0 = sat_quo(dquo[2*a],   dside.neg[2*a],   dside.ovf[2*a]);
      t1 = sat_quo(dquo[2*a+1], dside.neg[2*a+1], dside.ovf[2*a+1]);
      if (dside.par[a]) begin
        t_lo[a] = Q_MIN;
        t_hi[a] = Q_MAX;
      end else if (t0 > t1) begin
        t_lo[a] = t1;
        t_hi[a] = t0;
      end else begin
        t_lo[a] = t0;
        t_hi[a] = t1;
      end
    end
  end

  // Stage B: narrow the interval and decide hit
  q_t   tmin, tmax;
  logic b_valid_r, b_hit_r;
  q_t   b_tmin_r;
  logic [NAXIS-1:0][QW-1:0] b_org_r, b_dir_r;

  always_comb begin
    tmin = a_lo_r[0];
    tmax = a_hi_r[0];
    for (int a = 1; a < NAXIS; a++) begin
      if (a_lo_r[a] > tmin) tmin = a_lo_r[a];
      if (a_hi_r[a] < tmax) tmax = a_hi_r[a];
    end
  end

  // Stage C: direction times entry distance
  logic c_valid_r, c_hit_r;
  q_t   c_tmin_r;
  logic signed [2*QW-1:0] c_prod_r [NAXIS];
  logic [NAXIS-1:0][QW-1:0] c_org_r;

  // Stage D: scale, saturate, add origin
  logic signed [2*QW-1:0] sh [NAXIS];
  q_t   ps [NAXIS];
  logic signed [QW:0] sum [NAXIS];
  q_t   pt [NAXIS];

  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      sh[a] = c_prod_r[a] >>> FRAC;
      if (sh[a] > $signed({{QW{1'b0}}, Q_MAX}))      ps[a] = Q_MAX;
      else if (sh[a] < $signed({{QW{1'b1}}, Q_MIN})) ps[a] = Q_MIN;
      else                                           ps[a] = q_t'(sh[a][QW-1:0]);
      sum[a] = $signed({c_org_r[a][QW-1], c_org_r[a]}) + $signed({ps[a][QW-1], ps[a]});
      if (sum[a][QW] != sum[a][QW-1]) pt[a] = sum[a][QW] ? Q_MIN : Q_MAX;
      else                            pt[a] = q_t'(sum[a][QW-1:0]);
    end
  end

  logic out_valid_r, out_hit_r;
  logic [QW-1:0] out_entry_r;
  logic [2:0][QW-1:0] out_point_r;

  // Advance the valid chain when the output can move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= dvalid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NAXIS; a++) begin
        a_lo_r[a]   <= t_lo[a];
        a_hi_r[a]   <= t_hi[a];
        c_prod_r[a] <= $signed(b_dir_r[a]) * b_tmin_r;
        out_point_r[a] <= c_hit_r ? QW'(pt[a]) : '0;
      end
      a_pmiss_r <= |dside.pmiss;
      a_org_r   <= dside.org;
      a_dir_r   <= dside.dir;

      b_hit_r  <= !(a_pmiss_r || (tmin > tmax) || tmax[QW-1]);
      b_tmin_r <= tmin;
      b_org_r  <= a_org_r;
      b_dir_r  <= a_dir_r;

      c_hit_r  <= b_hit_r;
      c_tmin_r <= b_tmin_r;
      c_org_r  <= b_org_r;

      out_hit_r   <= c_hit_r;
      out_entry_r <= c_hit_r ? QW'(c_tmin_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_entry = out_entry_r;
  assign out_point = out_point_r;

endmodule

[rtl/ray_box_slab_test_top.sv]
// Channel  Direction  Ports                                   Handshake
// in       input      in_ray_*, in_box_* (12 x 32b signed)     in_valid / in_ready
// out      output     out_hit, out_entry_distance, out_hit_point_*  out_valid / out_ready
// cfg      input      cfg_data (17b parallel_epsilon)          cfg_valid / cfg_ready
//
// One transaction per cycle sustained while out_ready holds; the path runs through the
// front register, queue, 32-stage restoring divider, order, narrow, multiply, sum.
// The divider sets the latency: one quotient bit per stage over six lanes.
// rst_n is synchronous active low; epsilon resets to 66.
// An output stall freezes the back pipeline; the queue lets the front keep taking
// transactions until it fills.
module ray_box_slab_test_top #(
  parameter int QDEPTH = rbst_pkg::QDEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbst_pkg::EPS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [rbst_pkg::QW-1:0] in_ray_origin_x,
  input  logic signed [rbst_pkg::QW-1:0] in_ray_origin_y,
  input  logic signed [rbst_pkg::QW-1:0] in_ray_origin_z,
  input  logic signed [rbst_pkg::QW-1:0] in_ray_dir_x,
  input  logic signed [rbst_pkg::QW-1:0] in_ray_dir_y,
  input  logic signed [rbst_pkg::QW-1:0] in_ray_dir_z,
  input  logic signed [rbst_pkg::QW-1:0] in_box_min_x,
  input  logic signed [rbst_pkg::QW-1:0] in_box_min_y,
  input  logic signed [rbst_pkg::QW-1:0] in_box_min_z,
  input  logic signed [rbst_pkg::QW-1:0] in_box_max_x,
  input  logic signed [rbst_pkg::QW-1:0] in_box_max_y,
  input  logic signed [rbst_pkg::QW-1:0] in_box_max_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic signed [rbst_pkg::QW-1:0] out_entry_distance,
  output logic signed [rbst_pkg::QW-1:0] out_hit_point_x,
  output logic signed [rbst_pkg::QW-1:0] out_hit_point_y,
  output logic signed [rbst_pkg::QW-1:0] out_hit_point_z
);
  import rbst_pkg::*;

  logic [EPS_W-1:0] eps_r;
  logic             f_valid, q_full, q_valid, q_pop;
  fent_t            f_data, q_data;
  logic [2:0][QW-1:0] point;
  logic [QW-1:0]      entry;

  assign cfg_ready = 1'b1;

  // Hold the epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  rbst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .eps      (eps_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .org      ({in_ray_origin_z, in_ray_origin_y, in_ray_origin_x}),
    .dir      ({in_ray_dir_z, in_ray_dir_y, in_ray_dir_x}),
    .bmin     ({in_box_min_z, in_box_min_y, in_box_min_x}),
    .bmax     ({in_box_max_z, in_box_max_y, in_box_max_x}),
    .f_valid  (f_valid),
    .f_full   (q_full),
    .f_data   (f_data)
  );

  rbst_queue #(
    .DEPTH (QDEPTH),
    .W     ($bits(fent_t))
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .full       (q_full),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  rbst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_pop    (q_pop),
    .in_data   (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit),
    .out_entry (entry),
    .out_point (point)
  );

  assign out_entry_distance = $signed(entry);
  assign out_hit_point_x    = $signed(point[0]);
  assign out_hit_point_y    = $signed(point[1]);
  assign out_hit_point_z    = $signed(point[2]);

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_entry_distance == '0 && out_hit_point_x == '0 &&
                              out_hit_point_y == '0 && out_hit_point_z == '0)
    else $error("miss transaction carries nonzero fields");
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> eps_r == $past(cfg_data))
    else $error("epsilon register missed a write");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> f_valid && q_full)
    else $error("input stalled without a full queue");
`endif

endmodule
